FILE: hw/rtl/afr_pkg.sv
// ----------------------------------------------------------------------------
// afr_pkg
// Types and constants shared by the addressed frame receiver modules.
// ----------------------------------------------------------------------------
`default_nettype none

package afr_pkg;

	localparam logic [7:0] CFG_START_BYTE  = 8'd0;
	localparam logic [7:0] CFG_OWN_ADDRESS = 8'd1;

	localparam logic [7:0] RST_START_BYTE  = 8'd2;
	localparam logic [7:0] RST_OWN_ADDRESS = 8'd1;

	// payload store write request
	typedef struct packed {
		logic       we;
		logic [7:0] addr;
		logic [7:0] data;
	} afr_wr_t;

	// start of an accepted frame's output run
	typedef struct packed {
		logic       start;
		logic [7:0] opcode;
		logic [7:0] len;
	} afr_burst_t;

endpackage

`default_nettype wire

FILE: hw/rtl/afr_parser.sv
// ----------------------------------------------------------------------------
// afr_parser
// Frame header parser, checksum accumulator and payload store writer.
// ----------------------------------------------------------------------------
`default_nettype none

module afr_parser import afr_pkg::*; #(
	parameter int MAX_PAYLOAD = 64
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [7:0] cfg_index,
	input  wire logic [7:0] cfg_data,
	input  wire logic       in_accept,
	input  wire logic [7:0] rx_byte,
	output afr_wr_t         wr,
	output afr_burst_t      burst
);

	localparam logic [2:0] ST_WAIT_START = 3'd0;
	localparam logic [2:0] ST_ADDRESS    = 3'd1;
	localparam logic [2:0] ST_OPCODE     = 3'd2;
	localparam logic [2:0] ST_LENGTH     = 3'd3;
	localparam logic [2:0] ST_CHECKSUM   = 3'd4;
	localparam logic [2:0] ST_PAYLOAD    = 3'd5;

	localparam logic [7:0] MAX_LEN = 8'(MAX_PAYLOAD);

	logic [2:0] state_q;
	logic [7:0] start_byte_q;
	logic [7:0] own_addr_q;
	logic [7:0] opcode_q;
	logic [7:0] len_q;
	logic [7:0] exp_q;
	logic [7:0] sum_q;
	logic [7:0] fill_q;

	logic [7:0] sum_nx;
	logic [7:0] fill_nx;

	assign sum_nx  = sum_q + rx_byte;
	assign fill_nx = fill_q + 8'd1;

	always_comb begin
		wr.we    = in_accept && (state_q == ST_PAYLOAD);
		wr.addr  = fill_q;
		wr.data  = rx_byte;
		burst.start  = 1'b0;
		burst.opcode = opcode_q;
		burst.len    = len_q;
		if (in_accept) begin
			case (state_q)
				ST_CHECKSUM: begin
					burst.start = (len_q == 8'd0);
				end
				ST_PAYLOAD: begin
					burst.start = (fill_nx >= len_q) && ((exp_q + sum_nx) == 8'd0);
				end
				default: begin
					burst.start = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_byte_q <= RST_START_BYTE;
			own_addr_q   <= RST_OWN_ADDRESS;
		end else if (cfg_we) begin
			if (cfg_index == CFG_START_BYTE) begin
				start_byte_q <= cfg_data;
			end else if (cfg_index == CFG_OWN_ADDRESS) begin
				own_addr_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_WAIT_START;
			opcode_q <= 8'd0;
			len_q    <= 8'd0;
			exp_q    <= 8'd0;
			sum_q    <= 8'd0;
			fill_q   <= 8'd0;
		end else if (in_accept) begin
			case (state_q)
				ST_ADDRESS: begin
					state_q <= (rx_byte == own_addr_q) ? ST_OPCODE : ST_WAIT_START;
				end
				ST_OPCODE: begin
					opcode_q <= rx_byte;
					state_q  <= ST_LENGTH;
				end
				ST_LENGTH: begin
					if (rx_byte > MAX_LEN) begin
						state_q <= ST_WAIT_START;
					end else begin
						len_q   <= rx_byte;
						state_q <= ST_CHECKSUM;
					end
				end
				ST_CHECKSUM: begin
					exp_q   <= rx_byte;
					sum_q   <= 8'd0;
					fill_q  <= 8'd0;
					state_q <= (len_q != 8'd0) ? ST_PAYLOAD : ST_WAIT_START;
				end
				ST_PAYLOAD: begin
					sum_q  <= sum_nx;
					fill_q <= fill_nx;
					if (fill_nx >= len_q) begin
						state_q <= ST_WAIT_START;
					end
				end
				default: begin
					if (rx_byte == start_byte_q) begin
						opcode_q <= 8'd0;
						len_q    <= 8'd0;
						exp_q    <= 8'd0;
						sum_q    <= 8'd0;
						fill_q   <= 8'd0;
						state_q  <= ST_ADDRESS;
					end else begin
						state_q <= ST_WAIT_START;
					end
				end
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/afr_emitter.sv
// ----------------------------------------------------------------------------
// afr_emitter
// Payload store and output run sequencer; the store's read register is the
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module afr_emitter import afr_pkg::*; #(
	parameter int MAX_PAYLOAD = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  afr_wr_t          wr,
	input  afr_burst_t       burst,
	output logic             busy,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,
	output logic             m_tuser,
	output logic             m_tlast
);

	localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

	logic [7:0] mem [MAX_PAYLOAD];

	logic       busy_q;
	logic [7:0] cnt_q;
	logic [7:0] len_q;
	logic [7:0] op_q;

	logic       valid_q;
	logic [7:0] rdata_q;
	logic [7:0] out_op_q;
	logic [7:0] out_len_q;
	logic [7:0] out_idx_q;
	logic       out_has_q;
	logic       out_last_q;

	logic       issue;
	logic       is_last;
	logic [7:0] cnt_nx;

	assign cnt_nx  = cnt_q + 8'd1;
	assign issue   = busy_q && (!valid_q || m_tready);
	assign is_last = (len_q == 8'd0) || (cnt_nx == len_q);

	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem[wr.addr[AW-1:0]] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (issue && (len_q != 8'd0)) begin
			rdata_q <= mem[cnt_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			out_op_q   <= op_q;
			out_len_q  <= len_q;
			out_idx_q  <= cnt_q;
			out_has_q  <= (len_q != 8'd0);
			out_last_q <= is_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			valid_q <= 1'b0;
			cnt_q   <= 8'd0;
			len_q   <= 8'd0;
			op_q    <= 8'd0;
		end else begin
			if (burst.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 8'd0;
				len_q  <= burst.len;
				op_q   <= burst.opcode;
			end else if (issue) begin
				cnt_q <= cnt_nx;
				if (is_last) begin
					busy_q <= 1'b0;
				end
			end
			if (issue) begin
				valid_q <= 1'b1;
			end else if (m_tready) begin
				valid_q <= 1'b0;
			end
		end
	end

	assign busy     = busy_q;
	assign m_tvalid = valid_q;
	assign m_tuser  = out_has_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {3'd0, (out_has_q ? rdata_q : 8'd0), out_idx_q[5:0],
		out_len_q[6:0], out_op_q};

endmodule

`default_nettype wire

FILE: hw/rtl/addressed_frame_receiver.sv
// ----------------------------------------------------------------------------
// addressed_frame_receiver
// Parses start/address/opcode/length/checksum/payload frames from a byte
// stream and emits accepted frames as runs of payload bytes.
// ----------------------------------------------------------------------------
// Each received byte is one input item and is taken while s_tready is
// high. When a frame passes its address, length and checksum checks, its
// payload is read back from the payload store one entry per cycle while the
// output is not stalled and sent as a run of result items (one empty item
// for a zero-length frame); while that run is still being read out of the
// store, s_tready is low, so the input is held until the whole run is read.
// The last result of a run may still wait at the output while the next
// frame's bytes are taken. Configuration: index 0 start byte (reset 2),
// index 1 own address (reset 1); other indexes are ignored. The payload
// store has no reset and needs no clearing pass.
`default_nettype none

module addressed_frame_receiver import afr_pkg::*; #(
	parameter int MAX_PAYLOAD = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [7:0]  cfg_index,
	input  wire logic [7:0]  cfg_data,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,   // [7:0] opcode, [14:8] frame_length,
	                                    // [20:15] byte_index, [28:21] data_byte
	output logic             m_tuser,   // [0] has_data
	output logic             m_tlast
);

	afr_wr_t    wr;
	afr_burst_t burst;
	logic       busy;

	assign cfg_ready = 1'b1;
	assign s_tready  = !busy;

	afr_parser #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_accept (s_tvalid && s_tready),
		.rx_byte   (s_tdata),
		.wr        (wr),
		.burst     (burst)
	);

	afr_emitter #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) u_emitter (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (wr),
		.burst    (burst),
		.busy     (busy),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

`default_nettype wire

FILE: test/addressed_frame_receiver_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// addressed_frame_receiver_test
// Feeds the frame receiver a byte stream of good, damaged and foreign frames
// under random source and sink stalls, predicts every emitted payload item
// and compares the output stream field by field.
// ----------------------------------------------------------------------------

module addressed_frame_receiver_test;
	import afr_pkg::*;

	localparam int FRAME_MAX = 64;
	localparam int IDLE_PCT = 37;
	localparam int SETTLE_CYCLES = 80;
	localparam int STALL_LIMIT = 2000;
	localparam logic [7:0] CFG_UNUSED = 8'hFF;

	typedef enum logic [2:0] {
		PH_WAIT, PH_ADDR, PH_OPCODE, PH_LENGTH, PH_CHECKSUM, PH_PAYLOAD
	} rx_phase_t;

	typedef struct packed {
		logic [7:0] opcode;
		logic [6:0] frame_length;
		logic [5:0] byte_index;
		logic [7:0] data_byte;
		logic       has_data;
		logic       last;
	} frame_byte_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic [7:0]  cfg_index = 8'd0;
	logic [7:0]  cfg_data = 8'd0;
	logic        s_tvalid = 1'b0;
	logic [7:0]  s_tdata = 8'd0;
	logic        m_tready = 1'b0;
	logic        cfg_ready;
	logic        s_tready;
	logic        m_tvalid;
	logic [31:0] m_tdata;
	logic        m_tuser;
	logic        m_tlast;

	addressed_frame_receiver #(.MAX_PAYLOAD(FRAME_MAX)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	always #10 clk = ~clk;

	logic [7:0]  rx_bytes[$];
	frame_byte_t bytes_due[$];
	logic        rx_taken = 1'b0;
	logic        steady = 1'b0;
	int          mismatches = 0;
	int          stall_count = 0;

	// receiver model
	logic [7:0]  frame_start = RST_START_BYTE;
	logic [7:0]  frame_addr = RST_OWN_ADDRESS;
	rx_phase_t   parse_ph = PH_WAIT;
	logic [7:0]  frame_op = 8'd0;
	logic [6:0]  frame_len = 7'd0;
	logic [7:0]  frame_check = 8'd0;
	logic [7:0]  frame_sum = 8'd0;
	logic [6:0]  frame_fill = 7'd0;
	logic [7:0]  frame_store[FRAME_MAX];

	// stimulus view of the configuration
	logic [7:0]  cur_start = RST_START_BYTE;
	logic [7:0]  cur_addr = RST_OWN_ADDRESS;

	task automatic parse_rx_byte(input logic [7:0] b);
		int i;
		case (parse_ph)
		PH_ADDR: parse_ph = (b == frame_addr) ? PH_OPCODE : PH_WAIT;
		PH_OPCODE: begin
			frame_op = b;
			parse_ph = PH_LENGTH;
		end
		PH_LENGTH: begin
			if (b > FRAME_MAX) begin
				parse_ph = PH_WAIT;
			end else begin
				frame_len = b[6:0];
				parse_ph = PH_CHECKSUM;
			end
		end
		PH_CHECKSUM: begin
			frame_check = b;
			frame_sum = 8'd0;
			frame_fill = 7'd0;
			if (frame_len != 7'd0) begin
				parse_ph = PH_PAYLOAD;
			end else begin
				// empty frame: accepted without a sum check
				bytes_due.push_back({frame_op, 7'd0, 6'd0, 8'd0, 1'b0, 1'b1});
				parse_ph = PH_WAIT;
			end
		end
		PH_PAYLOAD: begin
			frame_store[frame_fill[5:0]] = b;
			frame_sum = frame_sum + b;
			frame_fill = frame_fill + 7'd1;
			if (frame_fill >= frame_len) begin
				if (frame_check == 8'(8'd0 - frame_sum)) begin
					for (i = 0; i < frame_len; i++)
						bytes_due.push_back({frame_op, frame_len, 6'(i), frame_store[i],
							1'b1, (i + 1 == frame_len)});
				end
				parse_ph = PH_WAIT;
			end
		end
		default: begin
			if (b == frame_start) begin
				frame_op = 8'd0;
				frame_len = 7'd0;
				frame_check = 8'd0;
				frame_sum = 8'd0;
				frame_fill = 7'd0;
				parse_ph = PH_ADDR;
			end else begin
				parse_ph = PH_WAIT;
			end
		end
		endcase
	endtask

	task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (want !== got) begin
			$display("%0t ns: %s expected %0h, got %0h", $time, name, want, got);
			mismatches++;
		end
	endtask

	// source side and sink ready
	always @(negedge clk) begin
		if (arst_n) begin
			if (!s_tvalid || rx_taken) begin
				if (rx_bytes.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
					s_tdata <= rx_bytes.pop_front();
					s_tvalid <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
			m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// handshakes, prediction, checking and watchdog
	always @(posedge clk) begin
		frame_byte_t got;
		frame_byte_t want;
		if (arst_n) begin
			rx_taken <= s_tvalid && s_tready;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
				CFG_START_BYTE: frame_start = cfg_data;
				CFG_OWN_ADDRESS: frame_addr = cfg_data;
				default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				parse_rx_byte(s_tdata);
			if (m_tvalid && m_tready) begin
				got = {m_tdata[7:0], m_tdata[14:8], m_tdata[20:15], m_tdata[28:21],
					m_tuser, m_tlast};
				if (bytes_due.size() == 0) begin
					$display("%0t ns: result expected none, got %h", $time, got);
					mismatches++;
				end else begin
					want = bytes_due.pop_front();
					check_field("opcode", want.opcode, got.opcode);
					check_field("frame_length", want.frame_length, got.frame_length);
					check_field("byte_index", want.byte_index, got.byte_index);
					check_field("data_byte", want.data_byte, got.data_byte);
					check_field("has_data", want.has_data, got.has_data);
					check_field("last", want.last, got.last);
				end
			end
			if ((cfg_valid && cfg_ready) || (s_tvalid && s_tready) || (m_tvalid && m_tready))
				stall_count = 0;
			else
				stall_count++;
			if (stall_count >= STALL_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	task automatic push_seq(input logic [63:0] seq, input int n);
		int k;
		for (k = 0; k < n; k++)
			rx_bytes.push_back(seq[8 * (n - 1 - k) +: 8]);
	endtask

	task automatic queue_frame(input logic [7:0] sb, input logic [7:0] ad,
		input logic [7:0] op, input logic [7:0] ln, input logic bad_sum);
		logic [7:0] pl[FRAME_MAX];
		logic [7:0] sum;
		logic [7:0] cs;
		int i;
		sum = 8'd0;
		rx_bytes.push_back(sb);
		rx_bytes.push_back(ad);
		rx_bytes.push_back(op);
		rx_bytes.push_back(ln);
		if (ln <= FRAME_MAX) begin
			for (i = 0; i < ln; i++) begin
				pl[i] = 8'($urandom_range(255));
				sum = sum + pl[i];
			end
			cs = 8'd0 - sum;
			if (bad_sum)
				cs = cs + 8'($urandom_range(1, 255));
			rx_bytes.push_back(cs);
			for (i = 0; i < ln; i++)
				rx_bytes.push_back(pl[i]);
		end
	endtask

	// mostly good frames, some damaged or foreign ones, a little line noise
	task automatic random_traffic(input int n_bytes);
		int added;
		int pick;
		int before_cnt;
		logic [7:0] ln;
		logic [7:0] op;
		added = 0;
		while (added < n_bytes) begin
			before_cnt = rx_bytes.size();
			pick = $urandom_range(99);
			op = 8'($urandom_range(255));
			ln = ($urandom_range(39) == 0) ? 8'(FRAME_MAX) : 8'($urandom_range(10));
			if (pick < 70)
				queue_frame(cur_start, cur_addr, op, ln, 1'b0);
			else if (pick < 80)
				queue_frame(cur_start, cur_addr, op, ln, 1'b1);
			else if (pick < 87)
				queue_frame(cur_start, cur_addr ^ 8'($urandom_range(1, 255)), op, ln, 1'b0);
			else if (pick < 93)
				queue_frame(cur_start, cur_addr, op, 8'($urandom_range(FRAME_MAX + 1, 255)), 1'b0);
			else
				rx_bytes.push_back(8'($urandom_range(255)));
			added += rx_bytes.size() - before_cnt;
		end
	endtask

	task automatic wait_until_idle;
		while (rx_bytes.size() != 0 || s_tvalid || bytes_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [7:0] idx, input logic [7:0] val);
		@(negedge clk);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_config(input logic [7:0] sb, input logic [7:0] ad);
		write_reg(CFG_START_BYTE, sb);
		write_reg(CFG_OWN_ADDRESS, ad);
		cur_start = sb;
		cur_addr = ad;
	endtask

	initial begin
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		// reset configuration: start 02, address 01
		push_seq(64'h00, 1);
		push_seq(64'h02_01_00_00_5A, 5);             // empty frame, sum not checked
		push_seq(64'h02_01_FF_03_FF_02_FF_00, 8);    // start byte inside payload
		push_seq(64'h02_05, 2);                      // foreign address
		push_seq(64'h02_01_10_41, 4);                // length one above max
		push_seq(64'h02_01_10_FF, 4);                // largest length byte
		push_seq(64'h02_01_20_01_00_05, 6);          // bad checksum
		wait_until_idle();

		set_config(8'h00, 8'hFF);
		random_traffic(10);
		wait_until_idle();

		set_config(8'hFF, 8'h00);
		random_traffic(10);
		wait_until_idle();

		write_reg(CFG_UNUSED, 8'h5A);
		set_config(8'($urandom_range(255)), 8'($urandom_range(255)));
		steady <= 1'b1;
		queue_frame(cur_start, cur_addr, 8'($urandom_range(255)), 8'(FRAME_MAX), 1'b0);
		random_traffic(6);
		wait_until_idle();
		steady <= 1'b0;

		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

FILE: addressed_frame_receiver.f
hw/rtl/afr_pkg.sv
hw/rtl/afr_parser.sv
hw/rtl/afr_emitter.sv
hw/rtl/addressed_frame_receiver.sv
test/addressed_frame_receiver_test.sv
